@@ hdl/inline_extent_map_defines.svh @@
`ifndef INLINE_EXTENT_MAP_DEFINES_SVH
`define INLINE_EXTENT_MAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define IEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define IEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/iem_pkg.sv @@
`timescale 1ns / 1ps

package iem_pkg;

  localparam int MAX_EXTENTS_DEF = 8;
  localparam int BLK_W = 48;
  localparam int LEN_W = 32;
  localparam int FLG_W = 16;
  localparam int SPB_W = 8;
  localparam int CNT_OUT_W = 4;
  localparam int IN_DATA_W = 144;
  localparam int OUT_DATA_W = 136;

  localparam logic [SPB_W-1:0] SPB_RESET = 8'd8;
  localparam logic [FLG_W-1:0] FLAG_WRITTEN = 16'd1;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOAD   = 2'd2,
    CMD_CLEAR  = 2'd3
  } iem_cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_SPACE  = 2'd2
  } iem_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LK_SCAN,
    ST_LK_HIT,
    ST_AP_CHK,
    ST_CL_EMIT,
    ST_EMIT
  } iem_state_t;

  typedef struct packed {
    logic [FLG_W-1:0] flags;
    logic [LEN_W-1:0] length;
    logic [BLK_W-1:0] physical;
    logic [BLK_W-1:0] logical;
  } iem_entry_t;

endpackage

@@ hdl/iem_table.sv @@
`timescale 1ns / 1ps

module iem_table #(
  parameter int DEPTH = iem_pkg::MAX_EXTENTS_DEF,
  parameter int AW = 3
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output iem_pkg::iem_entry_t  rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  iem_pkg::iem_entry_t  wr_data
);
  import iem_pkg::*;

  iem_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/inline_extent_map.sv @@
// flow: load and append reach the result register by ST_EMIT, append via ST_AP_CHK
//   if entries are held; a clear emits one result per cycle while the results are taken
// throughput: one item at a time, the next item taken the cycle after its last result is
//   registered; a lookup scans one table entry per cycle through the single read port
// reset: held count and sector counter cleared, sectors_per_block set to 8,
//   table contents left as they are (never read before written)
`timescale 1ns / 1ps
`include "inline_extent_map_defines.svh"

module inline_extent_map #(
  parameter int MAX_EXTENTS = iem_pkg::MAX_EXTENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [iem_pkg::SPB_W-1:0]       cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // file_block, physical_block, extent_length, extent_flags
  input  logic [iem_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // mapped_block, free_length, entry_count, sector_total, 4 zero bits
  output logic [iem_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);
  import iem_pkg::*;

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

  iem_state_t state, state_next;

  logic [CW-1:0]    held, held_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    clr_n, clr_n_next;
  logic [BLK_W-1:0] sector_count, sector_count_next;
  logic [SPB_W-1:0] spb;
  logic [BLK_W-1:0] lb_r, lb_r_next;
  logic [BLK_W-1:0] pb_r, pb_r_next;
  logic [BLK_W-1:0] hit_phys, hit_phys_next;
  logic [BLK_W-1:0] hit_off, hit_off_next;

  iem_status_t      res_status, res_status_next;
  logic [BLK_W-1:0] res_mapped, res_mapped_next;
  logic [LEN_W-1:0] res_free, res_free_next;

  logic             out_valid;
  iem_status_t      out_status;
  logic [BLK_W-1:0] out_mapped;
  logic [LEN_W-1:0] out_free;
  logic [CNT_OUT_W-1:0] out_count;
  logic [BLK_W-1:0] out_total;
  logic             out_last;

  logic             rd_en, wr_en;
  logic [IW-1:0]    rd_addr, wr_addr;
  iem_entry_t       rd_data, wr_data;

  logic             s_acc, out_free_slot, push, cl_last, hit, contig;
  iem_cmd_t         in_cmd;
  logic [BLK_W-1:0] in_lb, in_pb;
  logic [LEN_W-1:0] in_len;
  logic [FLG_W-1:0] in_flg;

  iem_table #(.DEPTH(MAX_EXTENTS), .AW(IW)) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_cmd = iem_cmd_t'(s_axis_tuser);
  assign in_lb  = s_axis_tdata[47:0];
  assign in_pb  = s_axis_tdata[95:48];
  assign in_len = s_axis_tdata[127:96];
  assign in_flg = s_axis_tdata[143:128];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign out_free_slot = !out_valid || m_axis_tready;
  assign cl_last       = (idx == clr_n - CW'(1));
  assign push          = out_free_slot && (state inside {ST_EMIT, ST_CL_EMIT});

  // start <= block < start + length, sum taken one bit wider
  assign hit = (lb_r >= rd_data.logical) &&
               ({1'b0, lb_r} < ({1'b0, rd_data.logical} + (BLK_W + 1)'(rd_data.length)));
  assign contig =
    (({1'b0, rd_data.logical} + (BLK_W + 1)'(rd_data.length)) == {1'b0, lb_r}) &&
    (({1'b0, rd_data.physical} + (BLK_W + 1)'(rd_data.length)) == {1'b0, pb_r});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          case (in_cmd)
            CMD_LOOKUP: state_next = (held == '0) ? ST_EMIT : ST_LK_SCAN;
            CMD_APPEND: state_next = (held == '0) ? ST_EMIT : ST_AP_CHK;
            CMD_LOAD:   state_next = ST_EMIT;
            CMD_CLEAR:  state_next = (held == '0) ? ST_EMIT : ST_CL_EMIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_LK_SCAN: begin
        if (hit) begin
          state_next = ST_LK_HIT;
        end else if (idx >= held) begin
          state_next = ST_EMIT;
        end
      end
      ST_LK_HIT:  state_next = ST_EMIT;
      ST_AP_CHK:  state_next = ST_EMIT;
      ST_CL_EMIT: begin
        if (out_free_slot && cl_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free_slot) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    held_next         = held;
    idx_next          = idx;
    clr_n_next        = clr_n;
    sector_count_next = sector_count;
    lb_r_next         = lb_r;
    pb_r_next         = pb_r;
    hit_phys_next     = hit_phys;
    hit_off_next      = hit_off;
    res_status_next   = res_status;
    res_mapped_next   = res_mapped;
    res_free_next     = res_free;
    rd_en             = 1'b0;
    rd_addr           = '0;
    wr_en             = 1'b0;
    wr_addr           = IW'(held);
    wr_data           = '{flags: FLAG_WRITTEN, length: LEN_W'(1), physical: pb_r,
                          logical: lb_r};
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          lb_r_next     = in_lb;
          pb_r_next     = in_pb;
          res_free_next = '0;
          case (in_cmd)
            CMD_LOOKUP: begin
              res_status_next = STAT_NOT_FOUND;
              res_mapped_next = '0;
              rd_en           = (held != '0);
              idx_next        = CW'(1);
            end
            CMD_APPEND: begin
              res_status_next = STAT_OK;
              res_mapped_next = in_pb;
              if (held == '0) begin
                wr_en             = 1'b1;
                wr_data           = '{flags: FLAG_WRITTEN, length: LEN_W'(1),
                                      physical: in_pb, logical: in_lb};
                held_next         = CW'(1);
                sector_count_next = sector_count + BLK_W'(spb);
              end else begin
                rd_en   = 1'b1;
                rd_addr = IW'(held - CW'(1));
              end
            end
            CMD_LOAD: begin
              res_mapped_next = in_pb;
              if (held >= MAX_CNT) begin
                res_status_next = STAT_NO_SPACE;
              end else begin
                res_status_next = STAT_OK;
                wr_en           = 1'b1;
                wr_data         = '{flags: in_flg, length: in_len, physical: in_pb,
                                    logical: in_lb};
                held_next       = held + CW'(1);
              end
            end
            CMD_CLEAR: begin
              res_status_next = STAT_OK;
              res_mapped_next = '0;
              held_next       = '0;
              clr_n_next      = held;
              idx_next        = '0;
              rd_en           = (held != '0);
            end
            default: res_status_next = STAT_OK;
          endcase
        end
      end
      ST_LK_SCAN: begin
        if (hit) begin
          hit_phys_next = rd_data.physical;
          hit_off_next  = lb_r - rd_data.logical;
        end else if (idx < held) begin
          rd_en    = 1'b1;
          rd_addr  = IW'(idx);
          idx_next = idx + CW'(1);
        end
      end
      ST_LK_HIT: begin
        res_status_next = STAT_OK;
        res_mapped_next = hit_phys + hit_off;
      end
      ST_AP_CHK: begin
        if (contig) begin
          wr_en             = 1'b1;
          wr_addr           = IW'(held - CW'(1));
          wr_data           = rd_data;
          wr_data.length    = rd_data.length + LEN_W'(1);
          sector_count_next = sector_count + BLK_W'(spb);
        end else if (held >= MAX_CNT) begin
          res_status_next = STAT_NO_SPACE;
          res_free_next   = LEN_W'(1);
        end else begin
          wr_en             = 1'b1;
          held_next         = held + CW'(1);
          sector_count_next = sector_count + BLK_W'(spb);
        end
      end
      ST_CL_EMIT: begin
        if (out_free_slot && !cl_last) begin
          rd_en    = 1'b1;
          rd_addr  = IW'(idx + CW'(1));
          idx_next = idx + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held         <= '0;
      sector_count <= '0;
      spb          <= SPB_RESET;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      held         <= held_next;
      sector_count <= sector_count_next;
      if (cfg_valid && cfg_ready) begin
        spb <= cfg_data;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    clr_n      <= clr_n_next;
    lb_r       <= lb_r_next;
    pb_r       <= pb_r_next;
    hit_phys   <= hit_phys_next;
    hit_off    <= hit_off_next;
    res_status <= res_status_next;
    res_mapped <= res_mapped_next;
    res_free   <= res_free_next;
    if (push) begin
      out_count <= CNT_OUT_W'(held);
      out_total <= sector_count;
      if (state == ST_CL_EMIT) begin
        out_status <= STAT_OK;
        out_mapped <= rd_data.physical;
        out_free   <= rd_data.length;
        out_last   <= cl_last;
      end else begin
        out_status <= res_status;
        out_mapped <= res_mapped;
        out_free   <= res_free;
        out_last   <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'd0, out_total, out_count, out_free, out_mapped};

  `IEM_ASSERT_IMPL(a_held_bound, 1'b1, held <= MAX_CNT, "held count above table depth")
  `IEM_ASSERT_NEXT(a_clear_empties, s_acc && in_cmd == CMD_CLEAR, held == '0, "clear left entries")
  `IEM_ASSERT_IMPL(a_clear_scan, state == ST_CL_EMIT, held == '0 && clr_n != '0 && idx < clr_n, "bad clear scan")
  `IEM_ASSERT_IMPL(a_nospace_last, out_valid && out_status == STAT_NO_SPACE, out_last, "no-space result not last")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import iem_pkg::*;

  localparam int NUM_EXT     = MAX_EXTENTS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 90;
  localparam logic [BLK_W-1:0] ALL48 = '1;

  typedef struct packed {
    iem_status_t      status;
    logic [BLK_W-1:0] block;
    logic [LEN_W-1:0] free_len;
    logic [3:0]       count;
    logic [BLK_W-1:0] sectors;
    logic             last;
  } map_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SPB_W-1:0]      cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // file_block, physical_block, extent_length, extent_flags
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // cmd
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // mapped_block, free_length, entry_count, sector_total, 4 zero bits
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  // shadow of the extent table
  logic [BLK_W-1:0] map_logical [NUM_EXT];
  logic [BLK_W-1:0] map_physical[NUM_EXT];
  logic [LEN_W-1:0] map_length  [NUM_EXT];
  logic [FLG_W-1:0] map_flags   [NUM_EXT];
  int               map_held = 0;
  logic [BLK_W-1:0] map_sectors = '0;
  logic [SPB_W-1:0] map_spb = SPB_RESET;

  map_result_t results_due[$];
  int          items_sent[4] = '{0, 0, 0, 0};
  int          results_checked = 0;
  int          mismatches = 0;
  int          burst_left = 0;
  int          cycles = 0;
  bit          hold_request = 1'b0;

  inline_extent_map #(.MAX_EXTENTS(NUM_EXT)) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, results_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void queue_result(iem_status_t st, logic [BLK_W-1:0] blk,
                                       logic [LEN_W-1:0] len, logic lst);
    map_result_t r;
    r.status   = st;
    r.block    = blk;
    r.free_len = len;
    r.count    = map_held[3:0];
    r.sectors  = map_sectors;
    r.last     = lst;
    results_due.push_back(r);
  endfunction

  function automatic void predict_extent_op(iem_cmd_t c, logic [BLK_W-1:0] lb,
                                            logic [BLK_W-1:0] pb, logic [LEN_W-1:0] len,
                                            logic [FLG_W-1:0] flg);
    bit        hit;
    int        t;
    int        n;
    logic [63:0] ext_end;
    hit = 1'b0;
    case (c)
      CMD_LOOKUP: begin
        // first covering extent wins, end computed without wrap
        for (int i = 0; i < map_held; i++) begin
          ext_end = {16'd0, map_logical[i]} + {32'd0, map_length[i]};
          if (!hit && lb >= map_logical[i] && {16'd0, lb} < ext_end) begin
            hit = 1'b1;
            queue_result(STAT_OK, map_physical[i] + (lb - map_logical[i]), '0, 1'b1);
          end
        end
        if (!hit) queue_result(STAT_NOT_FOUND, '0, '0, 1'b1);
      end
      CMD_APPEND: begin
        if (map_held > 0) begin
          t = map_held - 1;
          if ({16'd0, map_logical[t]} + {32'd0, map_length[t]} == {16'd0, lb} &&
              {16'd0, map_physical[t]} + {32'd0, map_length[t]} == {16'd0, pb}) begin
            map_length[t] = map_length[t] + 32'd1;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (map_held >= NUM_EXT) begin
            queue_result(STAT_NO_SPACE, pb, 32'd1, 1'b1);
            return;
          end
          map_logical[map_held]  = lb;
          map_physical[map_held] = pb;
          map_length[map_held]   = 32'd1;
          map_flags[map_held]    = FLAG_WRITTEN;
          map_held++;
        end
        map_sectors = map_sectors + {40'd0, map_spb};
        queue_result(STAT_OK, pb, '0, 1'b1);
      end
      CMD_LOAD: begin
        if (map_held >= NUM_EXT) begin
          queue_result(STAT_NO_SPACE, pb, '0, 1'b1);
        end else begin
          map_logical[map_held]  = lb;
          map_physical[map_held] = pb;
          map_length[map_held]   = len;
          map_flags[map_held]    = flg;
          map_held++;
          queue_result(STAT_OK, pb, '0, 1'b1);
        end
      end
      default: begin
        n = map_held;
        map_held = 0;
        if (n == 0) queue_result(STAT_OK, '0, '0, 1'b1);
        for (int i = 0; i < n; i++)
          queue_result(STAT_OK, map_physical[i], map_length[i], i == n - 1);
      end
    endcase
  endfunction

  task automatic send_item(iem_cmd_t c, logic [BLK_W-1:0] lb, logic [BLK_W-1:0] pb,
                           logic [LEN_W-1:0] len, logic [FLG_W-1:0] flg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {flg, len, pb, lb};
    s_axis_tuser  <= c;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    predict_extent_op(c, lb, pb, len, flg);
    items_sent[c]++;
    burst_left--;
  endtask

  // stop offering and wait until every result is in, then let the block settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (NUM_EXT + 8) @(posedge clk);
  endtask

  task automatic write_spb(logic [SPB_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    map_spb = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BLK_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) v = 64'($urandom_range(0, 255));
    return v[BLK_W-1:0];
  endfunction

  task automatic test_directed();
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_CLEAR, ALL48, ALL48, '1, '1);
    send_item(CMD_APPEND, 48'd0, 48'd0, '0, '0);
    send_item(CMD_APPEND, 48'd1, 48'd1, '0, '0);
    // physical gap, then logical gap: both start new extents
    send_item(CMD_APPEND, 48'd2, 48'd100, '0, '0);
    send_item(CMD_APPEND, 48'd10, 48'd101, '0, '0);
    send_item(CMD_LOOKUP, 48'd0, '0, '0, '0);
    send_item(CMD_LOOKUP, 48'd1, '0, '0, '0);
    send_item(CMD_LOOKUP, 48'd2, '0, '0, '0);
    send_item(CMD_LOOKUP, 48'd5, '0, '0, '0);
    // extent at the top of the block space, mapped block wraps
    send_item(CMD_LOAD, ALL48 - 48'd15, ALL48, '1, '1);
    send_item(CMD_LOOKUP, ALL48, '0, '0, '0);
    // zero-length extent never matches
    send_item(CMD_LOAD, 48'h1000, 48'h2000, '0, 16'h8000);
    send_item(CMD_LOOKUP, 48'h1000, '0, '0, '0);
    send_item(CMD_LOAD, 48'h3000, 48'h4000, 32'd4, 16'h0002);
    send_item(CMD_LOAD, 48'h4800, 48'h5800, 32'd2, 16'h0008);
    send_item(CMD_LOAD, 48'h5000, 48'h6000, 32'd4, 16'h0004);
    // full table: contiguous append still extends, others are refused
    send_item(CMD_APPEND, 48'h5004, 48'h6004, '0, '0);
    send_item(CMD_APPEND, 48'h7000, 48'h8000, '0, '0);
    send_item(CMD_LOAD, 48'h9000, 48'hA000, 32'd2, 16'h0001);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    // length wraps to zero on extension
    send_item(CMD_LOAD, 48'd0, 48'd0, '1, '0);
    send_item(CMD_APPEND, 48'hFFFF_FFFF, 48'hFFFF_FFFF, '0, '0);
    send_item(CMD_LOOKUP, 48'd0, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic test_sector_config();
    wait_drain();
    write_spb(8'd1);
    for (int i = 0; i < 4; i++) send_item(CMD_APPEND, 48'd64 + i, 48'd900 + i, '0, '0);
    wait_drain();
    write_spb(8'd128);
    for (int i = 0; i < 4; i++) send_item(CMD_APPEND, 48'd68 + i, 48'd904 + i, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic random_item();
    int               pick;
    int               i;
    iem_cmd_t         c;
    logic [BLK_W-1:0] lb;
    logic [BLK_W-1:0] pb;
    logic [LEN_W-1:0] len;
    logic [FLG_W-1:0] flg;
    pick = $urandom_range(0, 99);
    lb   = rand48();
    pb   = rand48();
    len  = $urandom;
    flg  = FLG_W'($urandom);
    if (pick < 10) begin
      c = iem_cmd_t'($urandom_range(0, 3));
    end else if (map_held == NUM_EXT && pick < 50) begin
      c = CMD_CLEAR;
    end else if (pick < 45) begin
      c = CMD_LOOKUP;
      if (map_held > 0 && $urandom_range(0, 3) != 0) begin
        i = $urandom_range(0, map_held - 1);
        if (map_length[i] == 0 || $urandom_range(0, 4) == 0)
          lb = map_logical[i] + map_length[i];
        else
          lb = map_logical[i] + $urandom_range(0, map_length[i] - 1);
      end
    end else if (pick < 75) begin
      c = CMD_APPEND;
      if (map_held > 0 && $urandom_range(0, 4) != 0) begin
        i  = map_held - 1;
        lb = map_logical[i] + map_length[i];
        pb = map_physical[i] + map_length[i];
        // sometimes only one side is contiguous
        case ($urandom_range(0, 5))
          0: lb = lb + 1;
          1: pb = pb + 1;
          default: ;
        endcase
      end
    end else if (pick < 92) begin
      c = CMD_LOAD;
      if ($urandom_range(0, 3) != 0) len = $urandom_range(1, 20);
      if (map_held > 0 && $urandom_range(0, 1) == 0)
        lb = map_logical[map_held - 1] + map_length[map_held - 1];
    end else begin
      c = CMD_CLEAR;
    end
    send_item(c, lb, pb, len, flg);
  endtask

  task automatic test_random(int n);
    for (int p = 0; p < 3; p++) begin
      wait_drain();
      write_spb(SPB_W'($urandom_range(1, 128)));
      for (int k = 0; k < n; k++) random_item();
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    write_spb(8'd8);
    hold_request = 1'b1;
    burst_left = 1000;
    for (int i = 0; i < NUM_EXT; i++)
      send_item(CMD_LOAD, rand48(), rand48(), LEN_W'($urandom_range(1, 9)),
                FLG_W'($urandom));
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < 7; i++) random_item();
    wait_drain();
  endtask

  // receiver: changing ready patterns, plus one long hold on request
  initial begin : rx_side
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= mode_left[0];
        endcase
      end
    end
  end

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at cycle %0d: expected %0h, got %0h", what, cycles, want, got);
  endtask

  always @(posedge clk) begin : check_out
    map_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected result", '0, m_axis_tdata[BLK_W-1:0]);
      end else begin
        want = results_due.pop_front();
        if (m_axis_tuser != want.status)         flag_mismatch("status", want.status, m_axis_tuser);
        if (m_axis_tdata[47:0] != want.block)    flag_mismatch("mapped_block", want.block,
                                                               m_axis_tdata[47:0]);
        if (m_axis_tdata[79:48] != want.free_len) flag_mismatch("free_length", want.free_len,
                                                                m_axis_tdata[79:48]);
        if (m_axis_tdata[83:80] != want.count)   flag_mismatch("entry_count", want.count,
                                                               m_axis_tdata[83:80]);
        if (m_axis_tdata[131:84] != want.sectors) flag_mismatch("sector_total", want.sectors,
                                                                m_axis_tdata[131:84]);
        if (m_axis_tlast != want.last)           flag_mismatch("last", want.last, m_axis_tlast);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sector_config();
    test_random(20);
    test_backpressure();
    wait_drain();
    repeat (4 * NUM_EXT + 16) @(posedge clk);
    if (results_due.size() != 0) flag_mismatch("results never delivered", results_due.size(), 0);
    $display("covered %0d lookups, %0d appends, %0d loads, %0d clears; %0d results checked",
             items_sent[CMD_LOOKUP], items_sent[CMD_APPEND], items_sent[CMD_LOAD],
             items_sent[CMD_CLEAR], results_checked);
    $display("full and wrapped extents, sectors per block 1 to 128, long output stall; %0d bad",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
